[design/capture_frequency_meter_defines.svh]
// Assertion macros shared by the capture frequency meter RTL.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef CAPTURE_FREQUENCY_METER_DEFINES_SVH
`define CAPTURE_FREQUENCY_METER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CFM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("capture frequency meter assertion failed");
`define CFM_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("capture frequency meter forbidden condition seen");
`else
`define CFM_ASSERT(lbl, clk, rst_n, prop)
`define CFM_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[design/cfm_pkg.sv]
// Types and constants of the capture frequency meter.
// No dependencies; used by cfm_back and the top level.
`timescale 1ns / 1ps

package cfm_pkg;

	localparam int TICK_W     = 24;
	localparam int FREQ_W     = 24;
	localparam int DIGIT_W    = 4;
	// Eight BCD digits cover every 24-bit frequency.
	localparam int BCD_DIGITS = 8;
	localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd500000;
	localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_CONV,
		B_DONE
	} back_state_t;

	// Largest value that n decimal digits can show, evaluated at elaboration.
	function automatic logic [63:0] dec_limit(input int n);
		logic [63:0] lim;
		lim = 64'd1;
		for (int i = 0; i < n; i++) begin
			lim = lim * 64'd10;
		end
		return lim - 64'd1;
	endfunction

endpackage

[design/cfm_front.sv]
// Front end of the capture frequency meter: pairs captures and forms the period.
// Depends on nothing but its ports; feeds cfm_queue.
`timescale 1ns / 1ps

module cfm_front #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [TIMER_WIDTH-1:0] capture_time,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic [TIMER_WIDTH-1:0] push_period,
	output logic                   push_zero
);

	logic                   awaiting_q;
	logic [TIMER_WIDTH-1:0] first_q;
	logic                   accept;

	// Only the closing capture of a pair needs room in the queue.
	assign in_stall    = awaiting_q && !push_ready;
	assign accept      = in_valid && !in_stall;
	assign push_valid  = in_valid && awaiting_q;
	assign push_period = capture_time - first_q;
	assign push_zero   = (capture_time == first_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			first_q    <= '0;
		end else if (accept) begin
			awaiting_q <= !awaiting_q;
			if (!awaiting_q) begin
				first_q <= capture_time;
			end
		end
	end

endmodule

[design/cfm_queue.sv]
// Small first-in first-out queue between the front and back ends.
// Depends on the assertion macro header only.
`timescale 1ns / 1ps
`include "capture_frequency_meter_defines.svh"

module cfm_queue #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CFM_NEVER(a_queue_overfill, clk, arst_n, count_q > CW'(DEPTH))
	`CFM_ASSERT(a_queue_push_only, clk, arst_n, (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)

endmodule

[design/cfm_back.sv]
// Back end of the capture frequency meter: iterative divider (skipped for a zero period),
// then bit-serial binary to BCD conversion and the output register. Uses cfm_pkg and the macros.
`timescale 1ns / 1ps
`include "capture_frequency_meter_defines.svh"

module cfm_back #(
	parameter int TIMER_WIDTH = 16,
	parameter int DIGIT_COUNT = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cfm_pkg::TICK_W-1:0]      tick_rate,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  logic [TIMER_WIDTH-1:0]          pop_period,
	input  logic                            pop_zero,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [TIMER_WIDTH-1:0]          period_ticks,
	output logic [cfm_pkg::FREQ_W-1:0]      frequency_hz,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_hundred_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_ten_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_hundreds,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_tens,
	output logic [cfm_pkg::DIGIT_W-1:0]     digit_ones,
	output logic                            zero_period,
	output logic                            out_of_range
);

	// Dividend 2*tick_rate + period, divisor 2*period.
	localparam int DVD_BASE = (cfm_pkg::TICK_W + 1 > TIMER_WIDTH) ?
		cfm_pkg::TICK_W + 1 : TIMER_WIDTH;
	localparam int DVD_W = DVD_BASE + 1;
	localparam int DVS_W = TIMER_WIDTH + 1;
	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int BCD_W = cfm_pkg::BCD_DIGITS * cfm_pkg::DIGIT_W;
	localparam logic [63:0] LIM = cfm_pkg::dec_limit(DIGIT_COUNT);

	cfm_pkg::back_state_t state_q, state_d;

	logic [DVD_W-1:0]           dvd_q;
	logic [DVS_W-1:0]           dvs_q;
	logic [DVS_W-1:0]           rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [TIMER_WIDTH-1:0]     period_q;
	logic                       zero_q;
	logic [cfm_pkg::FREQ_W-1:0] freq_q;
	logic                       over_q;
	logic [cfm_pkg::FREQ_W-1:0] bin_q;
	logic [BCD_W-1:0]           bcd_q;

	logic                       out_valid_q;
	logic [TIMER_WIDTH-1:0]     out_period_q;
	logic [cfm_pkg::FREQ_W-1:0] out_freq_q;
	logic [BCD_W-1:0]           out_bcd_q;
	logic                       out_zero_q;
	logic                       out_over_q;

	logic                       start;
	logic                       div_last;
	logic                       conv_last;
	logic                       load_out;
	logic [DVS_W:0]             trial;
	logic                       qbit;
	logic [cfm_pkg::FREQ_W-1:0] quot;
	logic                       over_d;
	logic [BCD_W-1:0]           bcd_adj;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfm_pkg::B_IDLE: if (pop_valid) state_d = pop_zero ? cfm_pkg::B_CONV : cfm_pkg::B_DIV;
			cfm_pkg::B_DIV:  if (div_last) state_d = cfm_pkg::B_CONV;
			cfm_pkg::B_CONV: if (conv_last) state_d = cfm_pkg::B_DONE;
			cfm_pkg::B_DONE: if (!out_valid_q || !out_stall) state_d = cfm_pkg::B_IDLE;
			default:         state_d = cfm_pkg::B_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop_ready = 1'b0;
		div_last  = 1'b0;
		conv_last = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			cfm_pkg::B_IDLE: pop_ready = 1'b1;
			cfm_pkg::B_DIV:  div_last  = (cnt_q == CNT_W'(DVD_W - 1));
			cfm_pkg::B_CONV: conv_last = (cnt_q == CNT_W'(cfm_pkg::FREQ_W - 1));
			cfm_pkg::B_DONE: load_out  = !out_valid_q || !out_stall;
			default:         pop_ready = 1'b0;
		endcase
	end

	assign start = pop_valid && pop_ready;

	// One restoring division step per cycle; quotient bits enter at the bottom.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});
	assign quot  = {dvd_q[cfm_pkg::FREQ_W-2:0], qbit};
	assign over_d = (64'(quot) > LIM);

	always_comb begin
		for (int i = 0; i < cfm_pkg::BCD_DIGITS; i++) begin
			bcd_adj[i*cfm_pkg::DIGIT_W +: cfm_pkg::DIGIT_W] =
				(bcd_q[i*cfm_pkg::DIGIT_W +: cfm_pkg::DIGIT_W] >= cfm_pkg::BCD_ADJ_MIN) ?
				bcd_q[i*cfm_pkg::DIGIT_W +: cfm_pkg::DIGIT_W] + cfm_pkg::BCD_ADJ_ADD :
				bcd_q[i*cfm_pkg::DIGIT_W +: cfm_pkg::DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfm_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			period_q <= pop_period;
			zero_q   <= pop_zero;
			dvd_q    <= DVD_W'({tick_rate, 1'b0}) + DVD_W'(pop_period);
			dvs_q    <= {pop_period, 1'b0};
			rem_q    <= '0;
			cnt_q    <= '0;
			freq_q   <= '0;
			over_q   <= 1'b0;
			bin_q    <= '0;
			bcd_q    <= '0;
		end else if (state_q == cfm_pkg::B_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			cnt_q <= div_last ? '0 : cnt_q + 1'b1;
			if (div_last) begin
				freq_q <= quot;
				over_q <= over_d;
				bin_q  <= over_d ? LIM[cfm_pkg::FREQ_W-1:0] : quot;
			end
		end else if (state_q == cfm_pkg::B_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[cfm_pkg::FREQ_W-1]};
			bin_q <= {bin_q[cfm_pkg::FREQ_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (load_out) begin
			out_period_q <= period_q;
			out_freq_q   <= freq_q;
			out_bcd_q    <= bcd_q;
			out_zero_q   <= zero_q;
			out_over_q   <= over_q;
		end
	end

	assign out_valid               = out_valid_q;
	assign period_ticks            = out_period_q;
	assign frequency_hz            = out_freq_q;
	assign digit_ones              = out_bcd_q[3:0];
	assign digit_tens              = out_bcd_q[7:4];
	assign digit_hundreds          = out_bcd_q[11:8];
	assign digit_thousands         = out_bcd_q[15:12];
	assign digit_ten_thousands     = out_bcd_q[19:16];
	assign digit_hundred_thousands = out_bcd_q[23:20];
	assign zero_period             = out_zero_q;
	assign out_of_range            = out_over_q;

	`CFM_ASSERT(a_zero_gives_nothing, clk, arst_n, (out_valid_q && out_zero_q) |-> (out_freq_q == '0 && !out_over_q))
	`CFM_ASSERT(a_idle_without_work, clk, arst_n, (state_q == cfm_pkg::B_IDLE && !pop_valid) |=> state_q == cfm_pkg::B_IDLE)
	`CFM_ASSERT(a_result_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == cfm_pkg::B_DONE)

endmodule

[design/capture_frequency_meter.sv]
// Top level of the capture frequency meter (reciprocal frequency counter).
// Instantiates cfm_front, cfm_queue and cfm_back; uses cfm_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  capture   in         in_valid / in_stall  capture_time
//  result    out        out_valid/out_stall  period, frequency, six digits, two flags
//  config    in         cfg_valid/cfg_ready  cfg_data (tick rate in Hz)
//
//  The first capture of a pair is always accepted and gives no beat. The second
//  is accepted while the two-entry queue has room. The back end then takes the
//  pair, runs one restoring division step per quotient bit, DVD_W steps in all (26
//  with a 16-bit timer; none for a zero period), converts the frequency to BCD one
//  bit at a time and loads the output register before it takes the next pair.
//  Reset clears the pairing state, the queue, the back end and the tick rate
//  (back to 500000 Hz). in_stall is raised only while a second capture is due
//  and the queue is full; a stalled result beat holds the back end in B_DONE.

module capture_frequency_meter #(
	parameter int TIMER_WIDTH = 16,
	parameter int DIGIT_COUNT = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cfm_pkg::TICK_W-1:0]  cfg_data,
	// Capture channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [TIMER_WIDTH-1:0]      capture_time,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [TIMER_WIDTH-1:0]      period_ticks,
	output logic [cfm_pkg::FREQ_W-1:0]  frequency_hz,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_hundred_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_ten_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_thousands,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_hundreds,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_tens,
	output logic [cfm_pkg::DIGIT_W-1:0] digit_ones,
	output logic                        zero_period,
	output logic                        out_of_range
);

	// Queue entries carry the period with its zero flag on top.
	localparam int QW = TIMER_WIDTH + 1;

	logic [cfm_pkg::TICK_W-1:0] tick_rate_q;

	logic                   push_valid;
	logic                   push_ready;
	logic [TIMER_WIDTH-1:0] push_period;
	logic                   push_zero;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;

	// The tick rate register takes a write in any cycle. The user must write it only
	// while the block is idle (the block does not enforce this), so the back end may read it directly.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= cfm_pkg::TICK_RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_rate_q <= cfg_data;
		end
	end

	// The front end pairs captures and forms the wrapped period.
	cfm_front #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.capture_time (capture_time),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_period  (push_period),
		.push_zero    (push_zero)
	);

	// The queue lets a further pair arrive while a division is running.
	cfm_queue #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_zero, push_period}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back end divides, converts to decimal and holds the result beat.
	cfm_back #(
		.TIMER_WIDTH (TIMER_WIDTH),
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.tick_rate               (tick_rate_q),
		.pop_valid               (pop_valid),
		.pop_ready               (pop_ready),
		.pop_period              (pop_data[TIMER_WIDTH-1:0]),
		.pop_zero                (pop_data[QW-1]),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.period_ticks            (period_ticks),
		.frequency_hz            (frequency_hz),
		.digit_hundred_thousands (digit_hundred_thousands),
		.digit_ten_thousands     (digit_ten_thousands),
		.digit_thousands         (digit_thousands),
		.digit_hundreds          (digit_hundreds),
		.digit_tens              (digit_tens),
		.digit_ones              (digit_ones),
		.zero_period             (zero_period),
		.out_of_range            (out_of_range)
	);

endmodule
